// ===== src/ucst_pkg.sv =====
// ----------------------------------------------------------------------------
// ucst_pkg
// Shared types and constants for the user context slot table.
// ----------------------------------------------------------------------------
package ucst_pkg;

   // Default sizes of the table
   localparam int SLOTS_DEF          = 16;
   localparam int CARRIERS_DEF       = 4;
   localparam int HARQ_PROCESSES_DEF = 8;

   // Fixed field widths
   localparam int KEY_W       = 16;
   localparam int OPCODE_W    = 2;
   localparam int CARRIER_W   = 2;
   localparam int HARQ_W      = 3;
   localparam int SEL_W       = 4;
   localparam int IDX_OUT_W   = 4;
   localparam int COUNT_OUT_W = 5;
   localparam int NDI_BITS    = 8;

   // Register port
   localparam int                CSR_ADDR_W   = 3;
   localparam int                CSR_DATA_W   = 32;
   localparam logic [KEY_W-1:0]  ABSENT_RESET = 16'hFFFF;
   // Word index of the absent identifier register
   localparam logic              CSR_IDX_ABSENT = 1'b0;

   // Initial NDI patterns written on add
   localparam logic [NDI_BITS-1:0] DL_NDI_INIT = 8'h01;
   localparam logic [NDI_BITS-1:0] UL_NDI_INIT = 8'hFF;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;  // accept request, run search, register result
      logic commit;   // write back and load response register
   } cmd_type;

endpackage

// ===== src/ue_context_slot_table.sv =====
// ----------------------------------------------------------------------------
// ue_context_slot_table
// Fixed table of user slots keyed by radio identifier: add, remove, find and
// read, with an absent-identifier register on the register port.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  req      req_valid / req_stall  opcode, user_key, carrier, harq_process,
//                                  slot_select
//  rsp      rsp_valid / rsp_stall  slot_index, ok, key_out, primary_carrier,
//                                  user_count
//  csr      APB write/read         absent_rnti at byte address 0
//
//  Each item has a search cycle (all keys compared at once,
//  lowest index wins) on the accept edge, then a write-back cycle.
//  The write-back cycle waits while the response register is full and stalled.
//  One item is in work at a time; req_stall is high during write-back.
//  Synchronous reset clears all slots, the count and the response valid.
// ----------------------------------------------------------------------------
module ue_context_slot_table #(
   parameter int SLOTS          = ucst_pkg::SLOTS_DEF,
   parameter int CARRIERS       = ucst_pkg::CARRIERS_DEF,
   parameter int HARQ_PROCESSES = ucst_pkg::HARQ_PROCESSES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ucst_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [ucst_pkg::KEY_W-1:0]       req_user_key,
   input  logic [ucst_pkg::CARRIER_W-1:0]   req_carrier,
   input  logic [ucst_pkg::HARQ_W-1:0]      req_harq_process,
   input  logic [ucst_pkg::SEL_W-1:0]       req_slot_select,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ucst_pkg::IDX_OUT_W-1:0]   rsp_slot_index,
   output logic                             rsp_ok,
   output logic [ucst_pkg::KEY_W-1:0]       rsp_key_out,
   output logic [ucst_pkg::CARRIER_W-1:0]   rsp_primary_carrier,
   output logic [ucst_pkg::COUNT_OUT_W-1:0] rsp_user_count,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ucst_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ucst_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ucst_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ucst_pkg::*;

   cmd_type          cmd;
   logic [KEY_W-1:0] absent_ff;
   logic             csr_hit;

   // Register decode: one word register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_ABSENT);

   always_ff @(posedge clock) begin
      if (reset) begin
         absent_ff <= ABSENT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         absent_ff <= csr_pwdata[KEY_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(absent_ff) : '0;

   ucst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ucst_datapath #(
      .SLOTS          (SLOTS),
      .CARRIERS       (CARRIERS),
      .HARQ_PROCESSES (HARQ_PROCESSES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_opcode          (req_opcode),
      .req_user_key        (req_user_key),
      .req_carrier         (req_carrier),
      .req_harq_process    (req_harq_process),
      .req_slot_select     (req_slot_select),
      .absent_rnti         (absent_ff),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_ok              (rsp_ok),
      .rsp_key_out         (rsp_key_out),
      .rsp_primary_carrier (rsp_primary_carrier),
      .rsp_user_count      (rsp_user_count)
   );

endmodule

// ===== src/ucst_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucst_ctrl
// Sequencer for the slot table: search cycle, then write-back cycle that
// waits for the response register to be free.
// ----------------------------------------------------------------------------
module ucst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ucst_pkg::cmd_type cmd
);
   import ucst_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // Response register can take a new transfer
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Decode commands from state
   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.commit  = (state_ff == ST_COMMIT) && rsp_free;
   end

   // Advance state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/ucst_datapath.sv =====
// ----------------------------------------------------------------------------
// ucst_datapath
// Slot storage, parallel key compare with lowest-index priority encode,
// write-back logic, user count and response register.
// ----------------------------------------------------------------------------
module ucst_datapath #(
   parameter int SLOTS          = ucst_pkg::SLOTS_DEF,
   parameter int CARRIERS       = ucst_pkg::CARRIERS_DEF,
   parameter int HARQ_PROCESSES = ucst_pkg::HARQ_PROCESSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ucst_pkg::cmd_type               cmd,
   input  logic [ucst_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [ucst_pkg::KEY_W-1:0]      req_user_key,
   input  logic [ucst_pkg::CARRIER_W-1:0]  req_carrier,
   input  logic [ucst_pkg::HARQ_W-1:0]     req_harq_process,
   input  logic [ucst_pkg::SEL_W-1:0]      req_slot_select,
   input  logic [ucst_pkg::KEY_W-1:0]      absent_rnti,
   output logic [ucst_pkg::IDX_OUT_W-1:0]  rsp_slot_index,
   output logic                            rsp_ok,
   output logic [ucst_pkg::KEY_W-1:0]      rsp_key_out,
   output logic [ucst_pkg::CARRIER_W-1:0]  rsp_primary_carrier,
   output logic [ucst_pkg::COUNT_OUT_W-1:0] rsp_user_count
);
   import ucst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Slot context
   logic                 active_ff     [SLOTS];
   logic [KEY_W-1:0]     key_ff        [SLOTS];
   logic [CARRIER_W-1:0] carrier_ff    [SLOTS];
   logic                 configured_ff [SLOTS];
   logic [NDI_BITS-1:0]  dl_ndi_ff     [SLOTS];
   logic [NDI_BITS-1:0]  ul_ndi_ff     [SLOTS];
   logic                 ul_wait_ff    [SLOTS];
   logic                 dl_wait_ff    [SLOTS];
   logic [CNT_W-1:0]     count_ff, count_in;

   // Captured operation
   op_type               op_ff;
   logic [KEY_W-1:0]     op_key_ff;
   logic [CARRIER_W-1:0] op_carrier_ff, carrier_clamp;
   logic [HARQ_W-1:0]    op_harq_ff;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   // Search results
   logic                 free_hit, match_hit, sel_in_range;
   logic [IDX_W-1:0]     free_idx, match_idx;

   // Write-back and response
   logic [KEY_W-1:0]     rd_key, kout;
   logic [CARRIER_W-1:0] rd_carrier, carr;
   logic [NDI_BITS-1:0]  ul_init;
   logic                 ok, wr_add, wr_remove;

   logic [IDX_OUT_W-1:0]   rsp_idx_ff;
   logic                   rsp_ok_ff;
   logic [KEY_W-1:0]       rsp_key_ff;
   logic [CARRIER_W-1:0]   rsp_carrier_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   // Find lowest free slot and lowest active match in parallel
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      match_hit = 1'b0;
      match_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!active_ff[s]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(s);
         end
         if (active_ff[s] && (key_ff[s] == req_user_key)) begin
            match_hit = 1'b1;
            match_idx = IDX_W'(s);
         end
      end
   end

   // Pick the slot for this opcode
   always_comb begin
      sel_in_range  = (32'(req_slot_select) < SLOTS);
      carrier_clamp = (32'(req_carrier) >= CARRIERS) ? CARRIER_W'(CARRIERS - 1)
                                                     : req_carrier;
      case (op_type'(req_opcode))
         OP_ADD: begin
            hit_in = free_hit;
            idx_in = free_idx;
         end
         OP_REMOVE, OP_FIND: begin
            hit_in = match_hit;
            idx_in = match_idx;
         end
         OP_READ: begin
            hit_in = sel_in_range;
            idx_in = IDX_W'(req_slot_select);
         end
         default: begin
            hit_in = 1'b0;
            idx_in = '0;
         end
      endcase
   end

   // Hold the request and search result for the write-back cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= op_type'(req_opcode);
         op_key_ff     <= req_user_key;
         op_carrier_ff <= carrier_clamp;
         op_harq_ff    <= req_harq_process;
         hit_ff        <= hit_in;
         idx_ff        <= idx_in;
      end
   end

   // Build the write-back and the response
   always_comb begin
      rd_key     = key_ff[idx_ff];
      rd_carrier = carrier_ff[idx_ff];
      ul_init    = UL_NDI_INIT;
      if (32'(op_harq_ff) < HARQ_PROCESSES) begin
         ul_init = UL_NDI_INIT & ~(NDI_BITS'(1) << op_harq_ff);
      end
      wr_add    = 1'b0;
      wr_remove = 1'b0;
      ok        = 1'b0;
      kout      = op_key_ff;
      carr      = '0;
      count_in  = count_ff;
      case (op_ff)
         OP_ADD: begin
            if (hit_ff) begin
               wr_add = 1'b1;
               ok     = 1'b1;
               carr   = op_carrier_ff;
               if (32'(count_ff) < SLOTS) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         OP_REMOVE: begin
            if (hit_ff) begin
               wr_remove = 1'b1;
               ok        = 1'b1;
               carr      = rd_carrier;
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         OP_FIND: begin
            if (hit_ff) begin
               ok   = 1'b1;
               carr = rd_carrier;
            end
         end
         OP_READ: begin
            kout = absent_rnti;
            if (hit_ff && (rd_key != '0)) begin
               kout = rd_key;
            end
            if (hit_ff && (kout != absent_rnti)) begin
               ok   = 1'b1;
               carr = rd_carrier;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Write back slot context and user count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            active_ff[s]     <= 1'b0;
            key_ff[s]        <= '0;
            carrier_ff[s]    <= '0;
            configured_ff[s] <= 1'b0;
            dl_ndi_ff[s]     <= '0;
            ul_ndi_ff[s]     <= '0;
            ul_wait_ff[s]    <= 1'b0;
            dl_wait_ff[s]    <= 1'b0;
         end
         count_ff <= '0;
      end else if (cmd.commit) begin
         if (wr_add) begin
            active_ff[idx_ff]     <= 1'b1;
            key_ff[idx_ff]        <= op_key_ff;
            carrier_ff[idx_ff]    <= op_carrier_ff;
            configured_ff[idx_ff] <= 1'b0;
            dl_ndi_ff[idx_ff]     <= DL_NDI_INIT;
            ul_ndi_ff[idx_ff]     <= ul_init;
            ul_wait_ff[idx_ff]    <= 1'b1;
            dl_wait_ff[idx_ff]    <= 1'b1;
         end
         if (wr_remove) begin
            active_ff[idx_ff]  <= 1'b0;
            key_ff[idx_ff]     <= absent_rnti;
            ul_wait_ff[idx_ff] <= 1'b0;
            dl_wait_ff[idx_ff] <= 1'b0;
         end
         count_ff <= count_in;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_idx_ff     <= ok ? IDX_OUT_W'(idx_ff) : '0;
         rsp_ok_ff      <= ok;
         rsp_key_ff     <= kout;
         rsp_carrier_ff <= carr;
         rsp_count_ff   <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_slot_index      = rsp_idx_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_key_out         = rsp_key_ff;
   assign rsp_primary_carrier = rsp_carrier_ff;
   assign rsp_user_count      = rsp_count_ff;

endmodule

// ===== src/ucst_checker.sv =====
// ----------------------------------------------------------------------------
// ucst_checker
// Port-level checks for the slot table, bound to the top level.
// ----------------------------------------------------------------------------
module ucst_checker #(
   parameter int SLOTS = ucst_pkg::SLOTS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ucst_pkg::IDX_OUT_W-1:0]   rsp_slot_index,
   input logic                             rsp_ok,
   input logic [ucst_pkg::KEY_W-1:0]       rsp_key_out,
   input logic [ucst_pkg::CARRIER_W-1:0]   rsp_primary_carrier,
   input logic [ucst_pkg::COUNT_OUT_W-1:0] rsp_user_count
);
   import ucst_pkg::*;

   // A failed operation reports slot zero and carrier zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_slot_index == '0) && (rsp_primary_carrier == '0))
      else $error("failed response carries a slot or carrier");

   // User count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_user_count) <= SLOTS))
      else $error("user count above table size");

   // One item in work: stall follows every accepted transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted during write-back");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_out)
         && $stable(rsp_ok) && $stable(rsp_user_count))
      else $error("stalled response changed");

endmodule

bind ue_context_slot_table ucst_checker #(.SLOTS(SLOTS)) u_ucst_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_slot_index      (rsp_slot_index),
   .rsp_ok              (rsp_ok),
   .rsp_key_out         (rsp_key_out),
   .rsp_primary_carrier (rsp_primary_carrier),
   .rsp_user_count      (rsp_user_count)
);
